// ===== src/cds_pkg.sv =====
// Package for the calendar date stepper: payload structs, command and status codes,
// microcode word layout with its program, and calendar helper functions.
// Standalone; used by src/calendar_date_stepper.sv and src/cds_checker.sv.
`default_nettype none

package cds_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int STEP_W  = 16;
    localparam int WDAY_W  = 3;
    localparam int YDAY_W  = 9;
    localparam int UPC_W   = 4;

    // commands
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_ADVANCE = 2'd1;
    localparam logic [1:0] CMD_RETREAT = 2'd2;
    localparam logic [1:0] CMD_QUERY   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_LIMIT   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [DAY_W-1:0]   load_day;
        logic [MONTH_W-1:0] load_month;
        logic [YEAR_W-1:0]  load_year;
        logic [STEP_W-1:0]  step_count;
    } in_t;

    typedef struct packed {
        logic [DAY_W-1:0]   cur_day;
        logic [MONTH_W-1:0] cur_month;
        logic [YEAR_W-1:0]  cur_year;
        logic [WDAY_W-1:0]  weekday;
        logic [YDAY_W-1:0]  year_day;
        logic [1:0]         status;
    } out_t;

    // datapath operations
    localparam logic [3:0] OP_NOP    = 4'd0;
    localparam logic [3:0] OP_ACCEPT = 4'd1;
    localparam logic [3:0] OP_STEP   = 4'd2;
    localparam logic [3:0] OP_LOAD   = 4'd3;
    localparam logic [3:0] OP_YY     = 4'd4;
    localparam logic [3:0] OP_Q100   = 4'd5;
    localparam logic [3:0] OP_SUM    = 4'd6;
    localparam logic [3:0] OP_MOD7   = 4'd7;
    localparam logic [3:0] OP_OUT    = 4'd8;

    // jump conditions: taken goes to target, else to the next word
    localparam logic [2:0] JC_NEXT    = 3'd0;
    localparam logic [2:0] JC_ALWAYS  = 3'd1;
    localparam logic [2:0] JC_NO_ACC  = 3'd2;
    localparam logic [2:0] JC_IS_LOAD = 3'd3;
    localparam logic [2:0] JC_MORE    = 3'd4;
    localparam logic [2:0] JC_BUSY    = 3'd5;

    // program addresses
    localparam logic [UPC_W-1:0] PC_IDLE   = 4'd0;
    localparam logic [UPC_W-1:0] PC_DECODE = 4'd1;
    localparam logic [UPC_W-1:0] PC_STEP   = 4'd2;
    localparam logic [UPC_W-1:0] PC_SKIP   = 4'd3;
    localparam logic [UPC_W-1:0] PC_LOAD   = 4'd4;
    localparam logic [UPC_W-1:0] PC_YY     = 4'd5;
    localparam logic [UPC_W-1:0] PC_Q100   = 4'd6;
    localparam logic [UPC_W-1:0] PC_SUM    = 4'd7;
    localparam logic [UPC_W-1:0] PC_MOD7   = 4'd8;
    localparam logic [UPC_W-1:0] PC_OUT    = 4'd9;

    typedef struct packed {
        logic [3:0]       op;
        logic [2:0]       cond;
        logic [UPC_W-1:0] target;
    } ctrl_t;

    function automatic ctrl_t ucode(input logic [UPC_W-1:0] pc);
        ctrl_t w;
        unique case (pc)
            PC_IDLE:   w = '{op: OP_ACCEPT, cond: JC_NO_ACC,  target: PC_IDLE};
            PC_DECODE: w = '{op: OP_NOP,    cond: JC_IS_LOAD, target: PC_LOAD};
            PC_STEP:   w = '{op: OP_STEP,   cond: JC_MORE,    target: PC_STEP};
            PC_SKIP:   w = '{op: OP_NOP,    cond: JC_ALWAYS,  target: PC_YY};
            PC_LOAD:   w = '{op: OP_LOAD,   cond: JC_NEXT,    target: PC_YY};
            PC_YY:     w = '{op: OP_YY,     cond: JC_NEXT,    target: PC_Q100};
            PC_Q100:   w = '{op: OP_Q100,   cond: JC_NEXT,    target: PC_SUM};
            PC_SUM:    w = '{op: OP_SUM,    cond: JC_NEXT,    target: PC_MOD7};
            PC_MOD7:   w = '{op: OP_MOD7,   cond: JC_NEXT,    target: PC_OUT};
            PC_OUT:    w = '{op: OP_OUT,    cond: JC_BUSY,    target: PC_OUT};
            default:   w = '{op: OP_NOP,    cond: JC_ALWAYS,  target: PC_IDLE};
        endcase
        return w;
    endfunction

    // floor(y / 100) for any 14-bit y, by reciprocal
    function automatic logic [7:0] div100(input logic [YEAR_W-1:0] y);
        logic [27:0] p;
        p = 28'(y) * 28'd10486;
        return p[27:20];
    endfunction

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [7:0]        q;
        logic [YEAR_W-1:0] r;
        q = div100(y);
        r = y - 14'(14'(q) * 14'd100);
        return (y[1:0] == 2'd0) && ((r != '0) || (q[1:0] == 2'd0));
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] n;
        case (m)
            4'd2:                    n = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
            default:                 n = 5'd31;
        endcase
        return n;
    endfunction

    // days before the first of month m
    function automatic logic [YDAY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [YDAY_W-1:0] n;
        case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    // month offsets of the weekday formula
    function automatic logic [2:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [2:0] n;
        case (m)
            4'd2:    n = 3'd3;
            4'd3:    n = 3'd2;
            4'd4:    n = 3'd5;
            4'd5:    n = 3'd0;
            4'd6:    n = 3'd3;
            4'd7:    n = 3'd5;
            4'd8:    n = 3'd1;
            4'd9:    n = 3'd4;
            4'd10:   n = 3'd6;
            4'd11:   n = 3'd2;
            4'd12:   n = 3'd4;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== src/calendar_date_stepper.sv =====
// Top level of the calendar date stepper: microcoded sequencer and its datapath.
// Depends on src/cds_pkg.sv.
// Sequence: a load runs DECODE, LOAD, YY, Q100, SUM, MOD7 and OUT; advance/retreat/query run
//   DECODE, the one-day-per-cycle STEP loop (a zero count costs as one) and SKIP before YY.
// Throughput: one transaction in flight; s_ready is high only while the sequencer idles,
//   even while a result waits in the output reg.
// Reset (aresetn low, synchronous): date 1 January 2000, sequencer idle, no result pending.
`default_nettype none

module calendar_date_stepper #(
    parameter int COUNT_BITS = 16,
    parameter int YEAR_MAX   = 9999
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire cds_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output cds_pkg::out_t      m_data
);

    // Only the low bits of step_count that fit the counter are used.
    localparam int CapW = (COUNT_BITS < cds_pkg::STEP_W) ? COUNT_BITS : cds_pkg::STEP_W;
    localparam logic [cds_pkg::YEAR_W-1:0] YearMaxW = cds_pkg::YEAR_W'(YEAR_MAX);

    // Sequencer
    logic [cds_pkg::UPC_W-1:0] upc_reg, upc_next;
    cds_pkg::ctrl_t            cw;
    logic                      jump;

    // Architectural date state
    logic [cds_pkg::DAY_W-1:0]   day_reg, day_next;
    logic [cds_pkg::MONTH_W-1:0] month_reg, month_next;
    logic [cds_pkg::YEAR_W-1:0]  year_reg, year_next;
    logic [COUNT_BITS-1:0]       days_left_reg, days_left_next;

    // Captured transaction
    logic [1:0]                  cmd_reg, cmd_next;
    logic [cds_pkg::DAY_W-1:0]   ld_reg, ld_next;
    logic [cds_pkg::MONTH_W-1:0] lm_reg, lm_next;
    logic [cds_pkg::YEAR_W-1:0]  ly_reg, ly_next;
    logic [1:0]                  status_reg, status_next;

    // Leap flags, registered from their year registers. The step loop consults the current
    // year's flag only around February, far from any year change, SUM after the year settles;
    // the load flag is registered from the captured load year during DECODE and read in LOAD.
    logic leap_reg, lleap_reg;

    // Weekday / ordinal scratch
    logic [cds_pkg::YEAR_W-1:0]  yy_reg, yy_next;
    logic [7:0]                  q100_reg, q100_next;
    logic [cds_pkg::YEAR_W:0]    sum_reg, sum_next;
    logic [cds_pkg::YDAY_W-1:0]  ord_reg, ord_next;
    logic [cds_pkg::WDAY_W-1:0]  wk_reg, wk_next;

    // Output register
    logic                        m_valid_reg, m_valid_next;
    cds_pkg::out_t               m_data_reg, m_data_next;

    logic        s_fire;
    logic        out_free;
    logic        fwd;
    logic        at_limit;
    logic        load_ok;
    logic [30:0] mod_prod;
    logic [12:0] mod_q;

    assign cw       = cds_pkg::ucode(upc_reg);
    assign s_ready  = aresetn && (upc_reg == cds_pkg::PC_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign fwd = (cmd_reg == cds_pkg::CMD_ADVANCE);
    assign at_limit = fwd ?
        ((month_reg == 4'd12) && (day_reg == 5'd31) && (year_reg >= YearMaxW)) :
        ((month_reg == 4'd1) && (day_reg == 5'd1) && (year_reg <= 14'd1));

    assign load_ok = (lm_reg >= 4'd1) && (lm_reg <= 4'd12) &&
                     (ly_reg >= 14'd1) && (ly_reg <= YearMaxW) &&
                     (ld_reg >= 5'd1) && (ld_reg <= cds_pkg::month_days(lm_reg, lleap_reg));

    // sum mod 7 by reciprocal, exact for any 15-bit sum
    assign mod_prod = 31'(sum_reg) * 31'd37450;
    assign mod_q    = mod_prod[30:18];

    // Datapath: one operation per control word
    always_comb begin
        day_next       = day_reg;
        month_next     = month_reg;
        year_next      = year_reg;
        days_left_next = days_left_reg;
        cmd_next       = cmd_reg;
        ld_next        = ld_reg;
        lm_next        = lm_reg;
        ly_next        = ly_reg;
        status_next    = status_reg;
        yy_next        = yy_reg;
        q100_next      = q100_reg;
        sum_next       = sum_reg;
        ord_next       = ord_reg;
        wk_next        = wk_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;

        unique case (cw.op)
            cds_pkg::OP_NOP: begin
            end
            cds_pkg::OP_ACCEPT: begin
                if (s_fire) begin
                    cmd_next    = s_data.cmd;
                    ld_next     = s_data.load_day;
                    lm_next     = s_data.load_month;
                    ly_next     = s_data.load_year;
                    status_next = cds_pkg::ST_OK;
                    if (s_data.cmd == cds_pkg::CMD_ADVANCE ||
                        s_data.cmd == cds_pkg::CMD_RETREAT) begin
                        days_left_next = COUNT_BITS'(s_data.step_count[CapW-1:0]);
                    end else begin
                        days_left_next = '0;
                    end
                end
            end
            cds_pkg::OP_STEP: begin
                if (days_left_reg != '0) begin
                    if (at_limit) begin
                        status_next    = cds_pkg::ST_LIMIT;
                        days_left_next = '0;
                    end else begin
                        days_left_next = days_left_reg - 1'b1;
                        if (fwd) begin
                            if (day_reg < cds_pkg::month_days(month_reg, leap_reg)) begin
                                day_next = day_reg + 1'b1;
                            end else if (month_reg < 4'd12) begin
                                month_next = month_reg + 1'b1;
                                day_next   = 5'd1;
                            end else begin
                                year_next  = year_reg + 1'b1;
                                month_next = 4'd1;
                                day_next   = 5'd1;
                            end
                        end else begin
                            if (day_reg > 5'd1) begin
                                day_next = day_reg - 1'b1;
                            end else if (month_reg > 4'd1) begin
                                month_next = month_reg - 1'b1;
                                day_next   = cds_pkg::month_days(month_reg - 1'b1, leap_reg);
                            end else begin
                                year_next  = year_reg - 1'b1;
                                month_next = 4'd12;
                                day_next   = 5'd31;
                            end
                        end
                    end
                end
            end
            cds_pkg::OP_LOAD: begin
                if (load_ok) begin
                    day_next   = ld_reg;
                    month_next = lm_reg;
                    year_next  = ly_reg;
                end else begin
                    status_next = cds_pkg::ST_INVALID;
                end
            end
            cds_pkg::OP_YY: begin
                // January and February count toward the previous year
                yy_next = (month_reg < 4'd3) ? year_reg - 1'b1 : year_reg;
            end
            cds_pkg::OP_Q100: begin
                q100_next = cds_pkg::div100(yy_reg);
            end
            cds_pkg::OP_SUM: begin
                sum_next = {1'b0, yy_reg} + 15'(yy_reg >> 2) - 15'(q100_reg)
                         + 15'(q100_reg >> 2) + 15'(cds_pkg::month_offset(month_reg))
                         + 15'(day_reg);
                // leap day counts only once past February
                ord_next = cds_pkg::days_before(month_reg) + 9'(day_reg)
                         + 9'((month_reg > 4'd2) && leap_reg);
            end
            cds_pkg::OP_MOD7: begin
                wk_next = 3'(sum_reg - 15'(mod_q) * 15'd7);
            end
            cds_pkg::OP_OUT: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    m_data_next.cur_day   = day_reg;
                    m_data_next.cur_month = month_reg;
                    m_data_next.cur_year  = year_reg;
                    m_data_next.weekday   = wk_reg;
                    m_data_next.year_day  = ord_reg;
                    m_data_next.status    = status_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer: conditional jump or fall through
    always_comb begin
        unique case (cw.cond)
            cds_pkg::JC_NEXT:    jump = 1'b0;
            cds_pkg::JC_ALWAYS:  jump = 1'b1;
            cds_pkg::JC_NO_ACC:  jump = !s_fire;
            cds_pkg::JC_IS_LOAD: jump = (cmd_reg == cds_pkg::CMD_LOAD);
            cds_pkg::JC_MORE:    jump = (days_left_next != '0);
            cds_pkg::JC_BUSY:    jump = !out_free;
            default:             jump = 1'b1;
        endcase
        upc_next = jump ? cw.target : upc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg       <= cds_pkg::PC_IDLE;
            m_valid_reg   <= 1'b0;
            day_reg       <= 5'd1;
            month_reg     <= 4'd1;
            year_reg      <= 14'd2000;
            days_left_reg <= '0;
        end else begin
            upc_reg       <= upc_next;
            m_valid_reg   <= m_valid_next;
            day_reg       <= day_next;
            month_reg     <= month_next;
            year_reg      <= year_next;
            days_left_reg <= days_left_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        ld_reg     <= ld_next;
        lm_reg     <= lm_next;
        ly_reg     <= ly_next;
        status_reg <= status_next;
        yy_reg     <= yy_next;
        q100_reg   <= q100_next;
        sum_reg    <= sum_next;
        ord_reg    <= ord_next;
        wk_reg     <= wk_next;
        m_data_reg <= m_data_next;
        leap_reg   <= cds_pkg::is_leap(year_reg);
        lleap_reg  <= cds_pkg::is_leap(ly_reg);
    end

endmodule

`default_nettype wire

// ===== src/cds_checker.sv =====
// Port-level checker for the calendar date stepper, with its bind statement.
// Depends on src/cds_pkg.sv and src/calendar_date_stepper.sv.
`default_nettype none

module cds_checker (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          s_valid,
    input wire logic          s_ready,
    input wire cds_pkg::in_t  s_data,
    input wire logic          m_valid,
    input wire logic          m_ready,
    input wire cds_pkg::out_t m_data
);

    // a waiting input transaction holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input changed while waiting");

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // nothing is pending right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.cur_month >= 4'd1) && (m_data.cur_month <= 4'd12) &&
                    (m_data.cur_day >= 5'd1) && (m_data.cur_year >= 14'd1) &&
                    (m_data.weekday <= 3'd6))
        else $error("result date out of range");

    a_year_day: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.year_day >= 9'd1) && (m_data.year_day <= 9'd366) &&
                    (m_data.status != 2'd3))
        else $error("bad ordinal or status");

endmodule

bind calendar_date_stepper cds_checker u_cds_checker (.*);

`default_nettype wire

// ===== sim/calendar_date_stepper_tb.sv =====
// Self-checking testbench for calendar_date_stepper: directed and random date commands.
// Keeps its own calendar model and compares every result transaction field by field.
// Depends on src/cds_pkg.sv and src/calendar_date_stepper.sv.
`default_nettype none

module calendar_date_stepper_tb;

    localparam int unsigned CAL_YEAR_MAX = 9999;
    localparam int          RANDOM_ITEMS = 800;
    localparam int unsigned LONG_HOLD    = 300;
    // Fixed allowance for reset, the long hold-off and the drain at the end.
    localparam int unsigned BASE_CYCLES  = 20_000;

    // Sakamoto month offsets, January first
    localparam int unsigned WDAY_OFFSET [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

    logic           aclk;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    cds_pkg::in_t   s_data  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    cds_pkg::out_t  m_data;

    // model of the date held by the block
    int unsigned cal_day   = 1;
    int unsigned cal_month = 1;
    int unsigned cal_year  = 2000;

    cds_pkg::out_t expected_dates [$];
    cds_pkg::out_t due;
    int unsigned   mismatch_count   = 0;
    int unsigned   cycle_count      = 0;
    // grows with every transaction sent: its day count plus overhead, four times over
    int unsigned   cycle_budget     = BASE_CYCLES;
    bit            quiet_stretch    = 1'b0;
    bit            hold_off_pending = 1'b0;

    calendar_date_stepper #(
        .COUNT_BITS(16),
        .YEAR_MAX  (CAL_YEAR_MAX)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // ---------------------------------------------------------------- calendar model

    function automatic bit leap_year(input int unsigned y);
        return (y % 4 == 0) && ((y % 400 == 0) || (y % 100 != 0));
    endfunction

    function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
        case (m)
            2:            return leap_year(y) ? 29 : 28;
            4, 6, 9, 11:  return 30;
            default:      return 31;
        endcase
    endfunction

    function automatic int unsigned weekday_number(input int unsigned d, input int unsigned m,
                                                   input int unsigned y);
        int unsigned yy;
        yy = (m < 3) ? y - 1 : y;
        return (yy + yy / 4 - yy / 100 + yy / 400 + WDAY_OFFSET[m - 1] + d) % 7;
    endfunction

    // leap day only counts once February is over
    function automatic int unsigned ordinal_day(input int unsigned d, input int unsigned m,
                                                input int unsigned y);
        int unsigned n;
        n = d;
        for (int unsigned i = 1; i < m; i++) n += month_length(i, 1);
        if (m > 2 && leap_year(y)) n += 1;
        return n;
    endfunction

    // Applies one accepted command to the model date and queues the expected result.
    task automatic apply_command(input cds_pkg::in_t t);
        cds_pkg::out_t r;
        logic [1:0]    st;
        int unsigned   left;
        int unsigned   ld, lm, ly;
        ld = 32'(t.load_day);
        lm = 32'(t.load_month);
        ly = 32'(t.load_year);
        st = cds_pkg::ST_OK;
        case (t.cmd)
            cds_pkg::CMD_LOAD: begin
                if (lm >= 1 && lm <= 12 && ly >= 1 && ly <= CAL_YEAR_MAX && ld >= 1 &&
                    ld <= month_length(lm, ly)) begin
                    cal_day   = ld;
                    cal_month = lm;
                    cal_year  = ly;
                end else begin
                    st = cds_pkg::ST_INVALID;
                end
            end
            cds_pkg::CMD_ADVANCE: begin
                left = 32'(t.step_count);
                while (left != 0) begin
                    if (cal_month == 12 && cal_day == 31 && cal_year >= CAL_YEAR_MAX) begin
                        st = cds_pkg::ST_LIMIT;
                        break;
                    end
                    if (cal_day < month_length(cal_month, cal_year)) begin
                        cal_day++;
                    end else if (cal_month < 12) begin
                        cal_month++;
                        cal_day = 1;
                    end else begin
                        cal_year++;
                        cal_month = 1;
                        cal_day   = 1;
                    end
                    left--;
                end
            end
            cds_pkg::CMD_RETREAT: begin
                left = 32'(t.step_count);
                while (left != 0) begin
                    if (cal_month == 1 && cal_day == 1 && cal_year <= 1) begin
                        st = cds_pkg::ST_LIMIT;
                        break;
                    end
                    if (cal_day > 1) begin
                        cal_day--;
                    end else if (cal_month > 1) begin
                        cal_month--;
                        cal_day = month_length(cal_month, cal_year);
                    end else begin
                        cal_year--;
                        cal_month = 12;
                        cal_day   = 31;
                    end
                    left--;
                end
            end
            default: begin
            end
        endcase
        r.cur_day   = cds_pkg::DAY_W'(cal_day);
        r.cur_month = cds_pkg::MONTH_W'(cal_month);
        r.cur_year  = cds_pkg::YEAR_W'(cal_year);
        r.weekday   = cds_pkg::WDAY_W'(weekday_number(cal_day, cal_month, cal_year));
        r.year_day  = cds_pkg::YDAY_W'(ordinal_day(cal_day, cal_month, cal_year));
        r.status    = st;
        expected_dates.push_back(r);
    endtask

    // ---------------------------------------------------------------- stimulus helpers

    // unused fields carry random junk
    function automatic cds_pkg::in_t load_item(input int unsigned d, input int unsigned m,
                                               input int unsigned y);
        cds_pkg::in_t t;
        t.cmd        = cds_pkg::CMD_LOAD;
        t.load_day   = cds_pkg::DAY_W'(d);
        t.load_month = cds_pkg::MONTH_W'(m);
        t.load_year  = cds_pkg::YEAR_W'(y);
        t.step_count = cds_pkg::STEP_W'($urandom);
        return t;
    endfunction

    function automatic cds_pkg::in_t step_item(input logic [1:0] c, input int unsigned n);
        cds_pkg::in_t t;
        t.cmd        = c;
        t.load_day   = cds_pkg::DAY_W'($urandom);
        t.load_month = cds_pkg::MONTH_W'($urandom);
        t.load_year  = cds_pkg::YEAR_W'($urandom);
        t.step_count = cds_pkg::STEP_W'(n);
        return t;
    endfunction

    function automatic int unsigned pick_year();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(1, 4);
            1:       return $urandom_range(CAL_YEAR_MAX - 3, CAL_YEAR_MAX);
            2:       return 100 * $urandom_range(1, 99);   // century rule
            default: return $urandom_range(1, CAL_YEAR_MAX);
        endcase
    endfunction

    function automatic int unsigned pick_count();
        int unsigned c;
        c = $urandom_range(0, 99);
        if (c < 60)      return $urandom_range(0, 40);
        else if (c < 90) return $urandom_range(41, 1500);
        else if (c < 99) return $urandom_range(1501, 10000);
        else             return $urandom_range(10001, 65535);
    endfunction

    function automatic cds_pkg::in_t random_item();
        cds_pkg::in_t t;
        int unsigned  pick, y, m;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            t = step_item(cds_pkg::CMD_LOAD, $urandom);
            // mostly well-formed dates; the rest is raw noise in every load field
            if ($urandom_range(0, 3) != 0) begin
                y = pick_year();
                m = $urandom_range(1, 12);
                t = load_item(($urandom_range(0, 3) == 0) ? month_length(m, y)
                                                           : $urandom_range(1, month_length(m, y)),
                              m, y);
            end
        end else if (pick < 60) begin
            t = step_item(cds_pkg::CMD_ADVANCE, pick_count());
        end else if (pick < 85) begin
            t = step_item(cds_pkg::CMD_RETREAT, pick_count());
        end else begin
            t = step_item(cds_pkg::CMD_QUERY, $urandom);
        end
        return t;
    endfunction

    // One input transaction: optional idle gap, then hold valid until accepted.
    task automatic send_item(input cds_pkg::in_t item);
        int unsigned gap;
        gap = quiet_stretch ? 0 : $urandom_range(0, 11);
        // sequencer overhead plus both idle gaps, and one cycle per day stepped
        cycle_budget += 4 * 64;
        if (item.cmd == cds_pkg::CMD_ADVANCE || item.cmd == cds_pkg::CMD_RETREAT)
            cycle_budget += 4 * 32'(item.step_count);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_command(item);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_reset_state();
        send_item(step_item(cds_pkg::CMD_QUERY, $urandom));          // Saturday 1 Jan 2000
    endtask

    task automatic test_loads();
        send_item(load_item(1, 1, 1));
        send_item(load_item(31, 12, CAL_YEAR_MAX));
        send_item(load_item(29, 2, 2000));                  // leap century
        send_item(load_item(29, 2, 1900));                  // not a leap year
        send_item(load_item(31, 0, 2000));
        send_item(load_item(31, 15, 16383));                // every load bit set
        send_item(load_item(15, 6, 0));
        send_item(load_item(0, 6, 2000));
        send_item(load_item(31, 4, 2021));
        send_item(load_item(10, 10, CAL_YEAR_MAX + 1));
    endtask

    task automatic test_stepping();
        send_item(load_item(31, 12, 1999));
        send_item(step_item(cds_pkg::CMD_ADVANCE, 1));               // year rollover
        send_item(step_item(cds_pkg::CMD_ADVANCE, 0));
        send_item(step_item(cds_pkg::CMD_RETREAT, 0));
        send_item(load_item(1, 3, 2000));
        send_item(step_item(cds_pkg::CMD_RETREAT, 1));               // back onto the leap day
        send_item(step_item(cds_pkg::CMD_QUERY, 16'hFFFF));
        send_item(step_item(cds_pkg::CMD_ADVANCE, 65535));
        send_item(step_item(cds_pkg::CMD_RETREAT, 65535));
    endtask

    task automatic test_calendar_limits();
        send_item(load_item(25, 12, CAL_YEAR_MAX));
        send_item(step_item(cds_pkg::CMD_ADVANCE, 10));              // stops at the top
        send_item(step_item(cds_pkg::CMD_ADVANCE, 0));               // zero count at the limit
        send_item(load_item(3, 1, 1));
        send_item(step_item(cds_pkg::CMD_RETREAT, 10));              // stops at 1 Jan 1
    endtask

    // Sink stops for a long stretch while back-to-back commands keep coming.
    task automatic test_backpressure();
        quiet_stretch    = 1'b1;
        hold_off_pending = 1'b1;
        for (int i = 0; i < 16; i++) begin
            send_item(($urandom_range(0, 1) == 0) ?
                      step_item(cds_pkg::CMD_QUERY, $urandom) :
                      step_item(cds_pkg::CMD_ADVANCE, $urandom_range(0, 20)));
        end
        quiet_stretch = 1'b0;
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 40 == 0) quiet_stretch = ($urandom_range(0, 3) == 0);
            send_item(random_item());
        end
        quiet_stretch = 1'b0;
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_dates.size() == 0) begin
                report_mismatch("result transaction with no command outstanding");
            end else begin
                due = expected_dates.pop_front();
                check_field("cur_day",   16'(m_data.cur_day),   16'(due.cur_day));
                check_field("cur_month", 16'(m_data.cur_month), 16'(due.cur_month));
                check_field("cur_year",  16'(m_data.cur_year),  16'(due.cur_year));
                check_field("weekday",   16'(m_data.weekday),   16'(due.weekday));
                check_field("year_day",  16'(m_data.year_day),  16'(due.year_day));
                check_field("status",    16'(m_data.status),    16'(due.status));
            end
        end
    end

    // result sink: random stalls, one long hold-off on request
    initial begin : result_sink
        int unsigned stall;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                stall = LONG_HOLD;
            end else begin
                stall = quiet_stretch ? 0 : $urandom_range(0, 11);
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= cycle_budget) begin
            report_mismatch($sformatf("timeout after %0d cycles, %0d results outstanding",
                                      cycle_count, expected_dates.size()));
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_state();
        test_loads();
        test_stepping();
        test_calendar_limits();
        test_backpressure();
        test_random_traffic();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_dates.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
